// File: sv/sgu_pkg.sv
`default_nettype none

package sgu_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int CFG_W  = 11;
    localparam int IDX_W  = 1;
    localparam int POS_W  = 10;
    localparam int GRAD_W = 11;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW_W = (CFG_W > WID_W) ? CFG_W : WID_W;
    localparam int CMPH_W = (CFG_W > HGT_W) ? CFG_W : HGT_W;
    localparam int PAIR_W = 2 * PIXEL_BITS;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] e1;
        logic [PIXEL_BITS-1:0] e2;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic                  interior;
        logic                  last_col;
        logic                  last_row;
    } pix_item_t;

    typedef struct packed {
        logic      valid;
        pix_item_t item;
    } stage_t;

    // Pixels are summed modulo the gradient width, which matches the
    // wrap of the result field for any pixel depth.
    function automatic logic [GRAD_W-1:0] ext(input logic [PIXEL_BITS-1:0] p);
        return GRAD_W'(p);
    endfunction

endpackage

`default_nettype wire

// File: sv/sgu_pixel_if.sv
`default_nettype none

interface sgu_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [sgu_pkg::PIXEL_BITS-1:0]  pixel_first;
    logic [sgu_pkg::PIXEL_BITS-1:0]  pixel_second;

    modport source (output valid, output pixel_first, output pixel_second, input ready);
    modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

`default_nettype wire

// File: sv/sgu_grad_if.sv
`default_nettype none

interface sgu_grad_if;
    logic                              valid;
    logic                              ready;
    logic [sgu_pkg::POS_W-1:0]         out_row;
    logic [sgu_pkg::POS_W-1:0]         out_col;
    logic signed [sgu_pkg::GRAD_W-1:0] grad_x_quarters;
    logic signed [sgu_pkg::GRAD_W-1:0] grad_y_quarters;
    logic signed [sgu_pkg::GRAD_W-1:0] grad_t_quarters;
    logic                              last_of_run;

    modport source (output valid, output out_row, output out_col,
                    output grad_x_quarters, output grad_y_quarters,
                    output grad_t_quarters, output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input grad_x_quarters, input grad_y_quarters,
                    input grad_t_quarters, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/sgu_ram.sv
`default_nettype none

module sgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same address return the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: sv/sgu_raster.sv
`default_nettype none

module sgu_raster (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sgu_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [sgu_pkg::CFG_W-1:0]     cfg_data,
    sgu_pixel_if.sink                          pix,
    input  wire logic                          advance,
    output sgu_pkg::stage_t                    stage_a,
    output logic                               ram_en,
    output logic [sgu_pkg::COL_W-1:0]          ram_addr,
    output logic [sgu_pkg::PAIR_W-1:0]         ram_wdata
);

    logic [sgu_pkg::CFG_W-1:0]  width_reg;
    logic [sgu_pkg::CFG_W-1:0]  height_reg;
    logic [sgu_pkg::ROW_W-1:0]  row_reg;
    logic [sgu_pkg::ROW_W-1:0]  row_next;
    logic [sgu_pkg::COL_W-1:0]  col_reg;
    logic [sgu_pkg::COL_W-1:0]  col_next;
    logic                       a_valid_reg;
    sgu_pkg::pix_item_t         a_item_reg;
    sgu_pkg::pix_item_t         a_item_next;

    logic [sgu_pkg::CMPW_W-1:0] w_raw;
    logic [sgu_pkg::CMPW_W-1:0] w_clamped;
    logic [sgu_pkg::CMPH_W-1:0] h_raw;
    logic [sgu_pkg::CMPH_W-1:0] h_clamped;
    logic [sgu_pkg::WID_W-1:0]  w_lim;
    logic [sgu_pkg::HGT_W-1:0]  h_lim;
    logic                       col_last;
    logic                       row_last;
    logic                       accept;

    assign pix.ready = !a_valid_reg || advance;
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        w_raw = sgu_pkg::CMPW_W'(width_reg);
        if (w_raw < sgu_pkg::CMPW_W'(2))
        begin
            w_clamped = sgu_pkg::CMPW_W'(2);
        end
        else if (w_raw > sgu_pkg::CMPW_W'(sgu_pkg::MAX_WIDTH))
        begin
            w_clamped = sgu_pkg::CMPW_W'(sgu_pkg::MAX_WIDTH);
        end
        else
        begin
            w_clamped = w_raw;
        end

        h_raw = sgu_pkg::CMPH_W'(height_reg);
        if (h_raw < sgu_pkg::CMPH_W'(2))
        begin
            h_clamped = sgu_pkg::CMPH_W'(2);
        end
        else if (h_raw > sgu_pkg::CMPH_W'(sgu_pkg::MAX_HEIGHT))
        begin
            h_clamped = sgu_pkg::CMPH_W'(sgu_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_clamped = h_raw;
        end

        w_lim    = sgu_pkg::WID_W'(w_clamped);
        h_lim    = sgu_pkg::HGT_W'(h_clamped);
        col_last = (sgu_pkg::WID_W'(col_reg) == w_lim - sgu_pkg::WID_W'(1));
        row_last = (sgu_pkg::HGT_W'(row_reg) == h_lim - sgu_pkg::HGT_W'(1));

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + sgu_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + sgu_pkg::COL_W'(1);
            row_next = row_reg;
        end

        a_item_next.e1       = pix.pixel_first;
        a_item_next.e2       = pix.pixel_second;
        a_item_next.row      = row_reg;
        a_item_next.col      = col_reg;
        a_item_next.interior = (row_reg != '0) && (col_reg != '0);
        a_item_next.last_col = (row_reg != '0) && col_last;
        a_item_next.last_row = row_last;
    end

    assign ram_en    = accept;
    assign ram_addr  = col_reg;
    assign ram_wdata = {pix.pixel_second, pix.pixel_first};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= sgu_pkg::WIDTH_RESET;
            height_reg  <= sgu_pkg::HEIGHT_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sgu_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    sgu_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                endcase
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end

            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= a_item_next;
        end
    end

    assign stage_a.valid = a_valid_reg;
    assign stage_a.item  = a_item_reg;

endmodule

`default_nettype wire

// File: sv/sgu_result.sv
`default_nettype none

module sgu_result (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sgu_pkg::stage_t               stage_a,
    input  wire logic [sgu_pkg::PAIR_W-1:0]    upper_pair,
    output logic                               advance,
    sgu_grad_if.source                         grad
);

    localparam int P = sgu_pkg::PIXEL_BITS;

    logic [sgu_pkg::PAIR_W-1:0] left_reg;
    logic [sgu_pkg::PAIR_W-1:0] upleft_reg;

    logic [2:0]                 mask_reg;
    logic [2:0]                 mask_next;
    logic [sgu_pkg::ROW_W-1:0]  row_reg;
    logic [sgu_pkg::COL_W-1:0]  col_reg;
    logic [sgu_pkg::GRAD_W-1:0] gx_reg;
    logic [sgu_pkg::GRAD_W-1:0] gy_reg;
    logic [sgu_pkg::GRAD_W-1:0] gt_reg;

    logic [sgu_pkg::GRAD_W-1:0] a1, a2, b1, b2, d1, d2, e1, e2;
    logic [sgu_pkg::GRAD_W-1:0] gx_next;
    logic [sgu_pkg::GRAD_W-1:0] gy_next;
    logic [sgu_pkg::GRAD_W-1:0] gt_next;
    logic [2:0]                 mask_rest;
    logic                       single;
    logic                       take;
    logic                       b_free;

    assign mask_rest = mask_reg & (mask_reg - 3'd1);
    assign single    = (mask_reg != 3'b000) && (mask_rest == 3'b000);
    assign take      = grad.valid && grad.ready;
    assign b_free    = (mask_reg == 3'b000) || (take && single);
    assign advance   = stage_a.valid && b_free;

    always_comb
    begin
        e1 = sgu_pkg::ext(stage_a.item.e1);
        e2 = sgu_pkg::ext(stage_a.item.e2);
        b1 = sgu_pkg::ext(upper_pair[P-1:0]);
        b2 = sgu_pkg::ext(upper_pair[2*P-1:P]);
        a1 = sgu_pkg::ext(upleft_reg[P-1:0]);
        a2 = sgu_pkg::ext(upleft_reg[2*P-1:P]);
        d1 = sgu_pkg::ext(left_reg[P-1:0]);
        d2 = sgu_pkg::ext(left_reg[2*P-1:P]);

        gx_next = (b1 + b2 + e1 + e2) - (a1 + a2 + d1 + d2);
        gy_next = (d1 + d2 + e1 + e2) - (a1 + a2 + b1 + b2);
        gt_next = (a2 + b2 + d2 + e2) - (a1 + b1 + d1 + e1);

        if (advance)
        begin
            mask_next = {stage_a.item.last_row, stage_a.item.last_col,
                         stage_a.item.interior};
        end
        else if (take)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= 3'b000;
            left_reg   <= '0;
            upleft_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (advance)
            begin
                left_reg   <= {stage_a.item.e2, stage_a.item.e1};
                upleft_reg <= upper_pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_reg <= stage_a.item.row;
            col_reg <= stage_a.item.col;
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            gt_reg  <= gt_next;
        end
    end

    always_comb
    begin
        grad.valid       = (mask_reg != 3'b000);
        grad.last_of_run = single;
        priority if (mask_reg[0])
        begin
            grad.out_row         = sgu_pkg::POS_W'(row_reg - sgu_pkg::ROW_W'(1));
            grad.out_col         = sgu_pkg::POS_W'(col_reg - sgu_pkg::COL_W'(1));
            grad.grad_x_quarters = gx_reg;
            grad.grad_y_quarters = gy_reg;
            grad.grad_t_quarters = gt_reg;
        end
        else if (mask_reg[1])
        begin
            grad.out_row         = sgu_pkg::POS_W'(row_reg - sgu_pkg::ROW_W'(1));
            grad.out_col         = sgu_pkg::POS_W'(col_reg);
            grad.grad_x_quarters = '0;
            grad.grad_y_quarters = '0;
            grad.grad_t_quarters = '0;
        end
        else
        begin
            grad.out_row         = sgu_pkg::POS_W'(row_reg);
            grad.out_col         = sgu_pkg::POS_W'(col_reg);
            grad.grad_x_quarters = '0;
            grad.grad_y_quarters = '0;
            grad.grad_t_quarters = '0;
        end
    end

endmodule

`default_nettype wire

// File: sv/spatiotemporal_gradient_2x2x2_unit.sv
`default_nettype none

// Takes co-located pixel pairs of two frames in raster order and gives, for
// every pixel, its x, y and time derivatives times four over the 2x2x2 cube
// below and to the right of it, tagged with row and column; pixels of the last
// row and last column get zeros, and pixels of row 0 are reported once the
// next row arrives. One item is taken per clock while the receiver keeps up:
// the item is registered as the previous row is read from the line store, the
// three differences go into a single result register, and that register hands
// results out one per cycle while the receiver is ready. An item causing two
// or three results (the end of any row but the first, any pixel of the last
// row but its first) holds the input until its last result is taken, still
// one result per pixel over a frame. Writing frame_width or frame_height
// restarts the frame at pixel (0, 0); write them only while the block is idle.
module spatiotemporal_gradient_2x2x2_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [sgu_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [sgu_pkg::CFG_W-1:0]   cfg_data,
    sgu_pixel_if.sink                        pix,
    sgu_grad_if.source                       grad
);

    sgu_pkg::stage_t            stage_a;
    logic                       advance;
    logic                       ram_en;
    logic [sgu_pkg::COL_W-1:0]  ram_addr;
    logic [sgu_pkg::PAIR_W-1:0] ram_wdata;
    logic [sgu_pkg::PAIR_W-1:0] ram_rdata;

    sgu_raster u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .advance   (advance),
        .stage_a   (stage_a),
        .ram_en    (ram_en),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    sgu_ram #(
        .WIDTH (sgu_pkg::PAIR_W),
        .DEPTH (sgu_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_en),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_en),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    sgu_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_a    (stage_a),
        .upper_pair (ram_rdata),
        .advance    (advance),
        .grad       (grad)
    );

`ifndef NO_ASSERTIONS
    a_empty_stage_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !stage_a.valid |-> pix.ready)
        else $error("input not ready with an empty input stage");

    a_burst_continues : assert property (@(posedge clk) disable iff (!rst_n)
        (grad.valid && grad.ready && !grad.last_of_run) |=> grad.valid)
        else $error("result burst broken before its last item");

    a_run_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (grad.valid && grad.ready && grad.last_of_run && !advance) |=> !grad.valid)
        else $error("result register not empty after the last item of a run");

    a_advance_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && grad.valid) |-> (grad.ready && grad.last_of_run))
        else $error("result register overwritten while results were pending");
`endif

endmodule

`default_nettype wire

// File: tb/spatiotemporal_gradient_2x2x2_unit_test.sv
`default_nettype none

module spatiotemporal_gradient_2x2x2_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [sgu_pkg::POS_W-1:0]         row;
        logic [sgu_pkg::POS_W-1:0]         col;
        logic signed [sgu_pkg::GRAD_W-1:0] gx;
        logic signed [sgu_pkg::GRAD_W-1:0] gy;
        logic signed [sgu_pkg::GRAD_W-1:0] gt;
        logic                              closes_run;
    } grad_result_t;

    class gradient_book;
        logic [sgu_pkg::CFG_W-1:0]      width_setting;
        logic [sgu_pkg::CFG_W-1:0]      height_setting;
        logic [sgu_pkg::PIXEL_BITS-1:0] upper_row_first [sgu_pkg::MAX_WIDTH];
        logic [sgu_pkg::PIXEL_BITS-1:0] upper_row_second [sgu_pkg::MAX_WIDTH];
        logic [sgu_pkg::PIXEL_BITS-1:0] left_first;
        logic [sgu_pkg::PIXEL_BITS-1:0] left_second;
        logic [sgu_pkg::PIXEL_BITS-1:0] upper_left_first;
        logic [sgu_pkg::PIXEL_BITS-1:0] upper_left_second;
        int unsigned                    row_at;
        int unsigned                    col_at;
        grad_result_t                   due[$];
        int unsigned                    errors;

        function new();
            width_setting = sgu_pkg::WIDTH_RESET;
            height_setting = sgu_pkg::HEIGHT_RESET;
            left_first = '0;
            left_second = '0;
            upper_left_first = '0;
            upper_left_second = '0;
            row_at = 0;
            col_at = 0;
            errors = 0;
            foreach (upper_row_first[i])
            begin
                upper_row_first[i] = '0;
                upper_row_second[i] = '0;
            end
        endfunction

        function void set_reg(logic [sgu_pkg::IDX_W-1:0] idx,
                              logic [sgu_pkg::CFG_W-1:0] value);
            if (idx == sgu_pkg::REG_FRAME_WIDTH)
            begin
                width_setting = value;
            end
            else if (idx == sgu_pkg::REG_FRAME_HEIGHT)
            begin
                height_setting = value;
            end
            row_at = 0;
            col_at = 0;
        endfunction

        function int unsigned span(logic [sgu_pkg::CFG_W-1:0] value, int unsigned top);
            if (value < 2)
                return 2;
            if (value > top)
                return top;
            return value;
        endfunction

        function void push_result(int unsigned r, int unsigned c, int gx, int gy, int gt);
            grad_result_t res;
            res.row = sgu_pkg::POS_W'(r);
            res.col = sgu_pkg::POS_W'(c);
            res.gx = gx[sgu_pkg::GRAD_W-1:0];
            res.gy = gy[sgu_pkg::GRAD_W-1:0];
            res.gt = gt[sgu_pkg::GRAD_W-1:0];
            res.closes_run = 1'b0;
            due.push_back(res);
        endfunction

        function void note_pixel(logic [sgu_pkg::PIXEL_BITS-1:0] p1,
                                 logic [sgu_pkg::PIXEL_BITS-1:0] p2);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            int unsigned n_before;
            int a1, a2, b1, b2, d1, d2, e1, e2;
            w = span(width_setting, sgu_pkg::MAX_WIDTH);
            h = span(height_setting, sgu_pkg::MAX_HEIGHT);
            r = row_at;
            c = col_at;
            if (c >= w)
                c = 0;
            if (r >= h)
                r = 0;
            e1 = p1;
            e2 = p2;
            b1 = upper_row_first[c];
            b2 = upper_row_second[c];
            a1 = upper_left_first;
            a2 = upper_left_second;
            d1 = left_first;
            d2 = left_second;
            n_before = due.size();
            if (r >= 1 && c >= 1)
            begin
                push_result(r - 1, c - 1,
                            (b1 + b2 + e1 + e2) - (a1 + a2 + d1 + d2),
                            (d1 + d2 + e1 + e2) - (a1 + a2 + b1 + b2),
                            (a2 + b2 + d2 + e2) - (a1 + b1 + d1 + e1));
            end
            if (r >= 1 && c == w - 1)
                push_result(r - 1, c, 0, 0, 0);
            if (r == h - 1)
                push_result(r, c, 0, 0, 0);
            if (due.size() > n_before)
                due[due.size() - 1].closes_run = 1'b1;
            upper_left_first = b1[sgu_pkg::PIXEL_BITS-1:0];
            upper_left_second = b2[sgu_pkg::PIXEL_BITS-1:0];
            left_first = p1;
            left_second = p2;
            upper_row_first[c] = p1;
            upper_row_second[c] = p2;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            col_at = c;
            row_at = r;
        endfunction

        function void match(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(grad_result_t got);
            grad_result_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: result for row %0d col %0d with none due",
                         $time, got.row, got.col);
                return;
            end
            want = due.pop_front();
            match("out_row", want.row, got.row);
            match("out_col", want.col, got.col);
            match("grad_x_quarters", $signed(want.gx), $signed(got.gx));
            match("grad_y_quarters", $signed(want.gy), $signed(got.gy));
            match("grad_t_quarters", $signed(want.gt), $signed(got.gt));
            match("last_of_run", want.closes_run, got.closes_run);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [sgu_pkg::IDX_W-1:0] cfg_index;
    logic [sgu_pkg::CFG_W-1:0] cfg_data;

    sgu_pixel_if pix_ch();
    sgu_grad_if  grad_ch();

    gradient_book book;
    grad_result_t seen;
    bit           no_idle = 1'b0;
    bit           hold_off_req = 1'b0;
    int unsigned  quiet_cycles = 0;

    spatiotemporal_gradient_2x2x2_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .grad      (grad_ch)
    );

    always #2 clk = ~clk;

    task automatic send_pixel(input logic [sgu_pkg::PIXEL_BITS-1:0] p1,
                              input logic [sgu_pkg::PIXEL_BITS-1:0] p2);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 30)
            begin
                pix_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_first <= p1;
        pix_ch.pixel_second <= p2;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        book.note_pixel(p1, p2);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_pixel(sgu_pkg::PIXEL_BITS'($urandom_range(0, 255)),
                       sgu_pkg::PIXEL_BITS'($urandom_range(0, 255)));
    endtask

    task automatic await_drain();
        pix_ch.valid <= 1'b0;
        while (book.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input logic [sgu_pkg::IDX_W-1:0] idx,
                               input int unsigned value);
        cfg_index <= idx;
        cfg_data <= sgu_pkg::CFG_W'(value);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_reg(idx, sgu_pkg::CFG_W'(value));
    endtask

    task automatic program_frame(input int unsigned w_raw, input int unsigned h_raw);
        program_reg(sgu_pkg::REG_FRAME_WIDTH, w_raw);
        program_reg(sgu_pkg::REG_FRAME_HEIGHT, h_raw);
    endtask

    initial
    begin
        bit held;
        grad_ch.ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                grad_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            grad_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && grad_ch.valid && grad_ch.ready)
        begin
            seen.row = grad_ch.out_row;
            seen.col = grad_ch.out_col;
            seen.gx = grad_ch.grad_x_quarters;
            seen.gy = grad_ch.grad_y_quarters;
            seen.gt = grad_ch.grad_t_quarters;
            seen.closes_run = grad_ch.last_of_run;
            book.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (grad_ch.valid && grad_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [2*sgu_pkg::PIXEL_BITS-1:0] cube_px [6][4];
        int unsigned                      random_sent;
        int unsigned                      n;
        book = new();
        cfg_we = 1'b0;
        cfg_index = sgu_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_first = '0;
        pix_ch.pixel_second = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset frame size, the first row gives no results.
        send_random(8);
        await_drain();

        // Each 2x2 frame is one cube; the item at the bottom right causes three results.
        cube_px = '{
            '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
            '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
            '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF},
            '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000},
            '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF},
            '{16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00}
        };
        program_frame(0, 1);
        foreach (cube_px[i, j])
            send_pixel(cube_px[i][j][2*sgu_pkg::PIXEL_BITS-1:sgu_pkg::PIXEL_BITS],
                       cube_px[i][j][sgu_pkg::PIXEL_BITS-1:0]);
        await_drain();

        no_idle = 1'b1;
        program_frame(4, 3);
        send_random(20);
        await_drain();
        no_idle = 1'b0;

        // The receiver holds off while the sender keeps offering items.
        program_frame(5, 2047);
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        send_random(30);
        no_idle = 1'b0;
        await_drain();

        random_sent = 0;
        while (random_sent < 24)
        begin
            n = $urandom_range(6, 16);
            program_frame($urandom_range(0, 12), $urandom_range(0, 6));
            send_random(n);
            random_sent += n;
            await_drain();
        end

        if (book.errors == 0 && book.due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
